// ----- hw/rtl/hlcr_pkg.sv -----
`timescale 1ns / 1ps

package hlcr_pkg;

    // Register lengths and the width of the random word.
    localparam int LFSR_LEN   = 43;
    localparam int CASR_LEN   = 37;
    localparam int WORD_LEN   = 32;
    localparam int OUT_WIDTH  = 32;
    localparam int CFG_DATA_W = 43;

    // Feedback taps of the LFSR (polynomial x^43 + x^41 + x^20 + x + 1).
    localparam int TAP_HI  = 42;
    localparam int TAP_MID = 40;
    localparam int TAP_LO  = 19;

    // Configuration register indexes.
    localparam logic CFG_LFSR_SEED = 1'b0;
    localparam logic CFG_CASR_SEED = 1'b1;

    // Seed values after reset: the top cell of each register is set.
    localparam logic [LFSR_LEN-1:0] LFSR_SEED_RST = {1'b1, {(LFSR_LEN-1){1'b0}}};
    localparam logic [CASR_LEN-1:0] CASR_SEED_RST = {1'b1, {(CASR_LEN-1){1'b0}}};

    // Cells of the CA register that follow rule 150 (both ends).
    localparam logic [CASR_LEN-1:0] CASR_END_MASK =
        {1'b1, {(CASR_LEN-2){1'b0}}, 1'b1};

    // Mask for the low OUT_WIDTH bits of the combined registers.
    localparam logic [CASR_LEN-1:0] WORD_MASK =
        CASR_LEN'((64'd1 << OUT_WIDTH) - 64'd1);

    // One result beat.
    typedef struct packed {
        logic [WORD_LEN-1:0] random_word;
        logic [LFSR_LEN-1:0] lfsr_bits;
        logic [CASR_LEN-1:0] casr_bits;
    } hlcr_result_t;

    // One step of the Fibonacci LFSR: shift up, feedback into cell 0.
    function automatic logic [LFSR_LEN-1:0] lfsr_step(input logic [LFSR_LEN-1:0] r);
        logic fb;
        fb = r[TAP_HI] ^ r[TAP_MID] ^ r[TAP_LO] ^ r[0];
        return {r[LFSR_LEN-2:0], fb};
    endfunction

    // One step of the cyclic CA register: rule 90 inside, rule 150 at the ends.
    function automatic logic [CASR_LEN-1:0] casr_step(input logic [CASR_LEN-1:0] t);
        logic [CASR_LEN-1:0] rotl;
        logic [CASR_LEN-1:0] rotr;
        rotl = {t[CASR_LEN-2:0], t[CASR_LEN-1]};
        rotr = {t[0], t[CASR_LEN-1:1]};
        return rotl ^ rotr ^ (t & CASR_END_MASK);
    endfunction

    // Random word from the two new registers.
    function automatic logic [WORD_LEN-1:0] mix_word(input logic [LFSR_LEN-1:0] l,
                                                     input logic [CASR_LEN-1:0] c);
        logic [CASR_LEN-1:0] x;
        x = (l[CASR_LEN-1:0] ^ c) & WORD_MASK;
        return x[WORD_LEN-1:0];
    endfunction

endpackage

// ----- hw/rtl/hlcr_step.sv -----
`timescale 1ns / 1ps

module hlcr_step (
    input  logic                          reseed,
    input  logic [hlcr_pkg::LFSR_LEN-1:0] lfsr_cur,
    input  logic [hlcr_pkg::CASR_LEN-1:0] casr_cur,
    input  logic [hlcr_pkg::LFSR_LEN-1:0] lfsr_seed,
    input  logic [hlcr_pkg::CASR_LEN-1:0] casr_seed,
    output hlcr_pkg::hlcr_result_t        result
);
    import hlcr_pkg::*;

    logic [LFSR_LEN-1:0] lfsr_base;
    logic [CASR_LEN-1:0] casr_base;
    logic [LFSR_LEN-1:0] lfsr_new;
    logic [CASR_LEN-1:0] casr_new;

    // A reseed beat starts from the seeds instead of the running state.
    assign lfsr_base = reseed ? lfsr_seed : lfsr_cur;
    assign casr_base = reseed ? casr_seed : casr_cur;

    // Advance both registers by one step and combine them.
    assign lfsr_new = lfsr_step(lfsr_base);
    assign casr_new = casr_step(casr_base);

    assign result.random_word = mix_word(lfsr_new, casr_new);
    assign result.lfsr_bits   = lfsr_new;
    assign result.casr_bits   = casr_new;

endmodule

// ----- hw/rtl/hlcr_ostage.sv -----
`timescale 1ns / 1ps

module hlcr_ostage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  hlcr_pkg::hlcr_result_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output hlcr_pkg::hlcr_result_t out_data
);
    import hlcr_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    hlcr_result_t data_reg;

    // The stage takes a new beat whenever it is empty or is drained this cycle.
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/hybrid_lfsr_casr_rng_core.sv -----
`timescale 1ns / 1ps
// Hybrid LFSR / cellular-automaton random word source.
// Each beat on the s_ channel requests one step of a 43-bit Fibonacci LFSR
// and a 37-cell rule 90/150 CA register; s_reseed set loads both from the
// seed registers before stepping. Each request yields exactly one m_ beat
// carrying the random word (XOR of the low bits of both registers) and the
// full contents of both registers after the step.
// Seeds are written through cfg_wr_en / cfg_index / cfg_wr_data; the user
// must do so only while the block is idle, which the block does not enforce;
// a new seed takes effect at the next reseed. A request accepted on s_ is on
// m_ in the following cycle. Throughput is one beat per cycle while m_ready
// is high, set by the single output register after the XOR next-state logic.
// When the receiver stalls the result holds in the output register and
// s_ready drops until it is taken; s_ready stays high while the register is
// drained in the same cycle.
// Reset loads both seeds with their top cell set, copies them into the
// running registers and empties the output register.

module hybrid_lfsr_casr_rng_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_reseed,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [hlcr_pkg::WORD_LEN-1:0]   m_random_word,
    output logic [hlcr_pkg::LFSR_LEN-1:0]   m_lfsr_bits,
    output logic [hlcr_pkg::CASR_LEN-1:0]   m_casr_bits,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [hlcr_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import hlcr_pkg::*;

    logic [LFSR_LEN-1:0] lfsr_seed_reg;
    logic [CASR_LEN-1:0] casr_seed_reg;
    logic [LFSR_LEN-1:0] lfsr_reg;
    logic [CASR_LEN-1:0] casr_reg;
    hlcr_result_t        step_res;
    hlcr_result_t        out_res;
    logic                accept;

    assign accept = s_valid && s_ready;

    // Seed registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_seed_reg <= LFSR_SEED_RST;
            casr_seed_reg <= CASR_SEED_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LFSR_SEED: lfsr_seed_reg <= cfg_wr_data[LFSR_LEN-1:0];
                CFG_CASR_SEED: casr_seed_reg <= cfg_wr_data[CASR_LEN-1:0];
                default: ;
            endcase
        end
    end

    // Next-state logic for one step.
    hlcr_step u_step (
        .reseed    (s_reseed),
        .lfsr_cur  (lfsr_reg),
        .casr_cur  (casr_reg),
        .lfsr_seed (lfsr_seed_reg),
        .casr_seed (casr_seed_reg),
        .result    (step_res)
    );

    // Running generator state advances once per accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= LFSR_SEED_RST;
            casr_reg <= CASR_SEED_RST;
        end else if (accept) begin
            lfsr_reg <= step_res.lfsr_bits;
            casr_reg <= step_res.casr_bits;
        end
    end

    // Output register with backpressure.
    hlcr_ostage u_ostage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (step_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_random_word = out_res.random_word;
    assign m_lfsr_bits   = out_res.lfsr_bits;
    assign m_casr_bits   = out_res.casr_bits;

endmodule

// ----- hw/rtl/hlcr_checker.sv -----
`timescale 1ns / 1ps

module hlcr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_reseed,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [hlcr_pkg::WORD_LEN-1:0]   m_random_word,
    input logic [hlcr_pkg::LFSR_LEN-1:0]   m_lfsr_bits,
    input logic [hlcr_pkg::CASR_LEN-1:0]   m_casr_bits
);
    import hlcr_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_random_word)
            && $stable(m_lfsr_bits) && $stable(m_casr_bits))
        else $error("stalled result beat changed");

    // The random word is always the mix of the two registers shown with it.
    a_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_random_word == mix_word(m_lfsr_bits, m_casr_bits))
        else $error("random word does not match register contents");

    // A stepping beat that follows a delivered beat continues from it.
    a_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && s_valid && s_ready && !s_reseed
            |=> m_valid && m_lfsr_bits == lfsr_step($past(m_lfsr_bits))
                && m_casr_bits == casr_step($past(m_casr_bits)))
        else $error("generator state did not continue from the last result");

    // An empty output register never blocks the request side.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request side stalled with empty output");

endmodule

bind hybrid_lfsr_casr_rng_core hlcr_checker u_hlcr_checker (.*);
